// ===== hdl/cfpd_pkg.sv =====
package cfpd_pkg;

  // Frame parser phases
  localparam logic [3:0] PhMark1 = 4'd0;
  localparam logic [3:0] PhMark2 = 4'd1;
  localparam logic [3:0] PhVer   = 4'd2;
  localparam logic [3:0] PhType  = 4'd3;
  localparam logic [3:0] PhSeq0  = 4'd4;
  localparam logic [3:0] PhSeq1  = 4'd5;
  localparam logic [3:0] PhCmd0  = 4'd6;
  localparam logic [3:0] PhCmd1  = 4'd7;
  localparam logic [3:0] PhSt0   = 4'd8;
  localparam logic [3:0] PhSt1   = 4'd9;
  localparam logic [3:0] PhLen0  = 4'd10;
  localparam logic [3:0] PhLen1  = 4'd11;
  localparam logic [3:0] PhData  = 4'd12;
  localparam logic [3:0] PhCrc0  = 4'd13;
  localparam logic [3:0] PhCrc1  = 4'd14;

  // Result kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindCrcGood = 2'd1;
  localparam logic [1:0] KindCrcBad  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMarkFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMarkSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 2'd2;

  localparam logic [7:0]  MarkFirstRst  = 8'hAA;
  localparam logic [7:0]  MarkSecondRst = 8'h55;
  localparam logic [15:0] MaxPayloadRst = 16'd128;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_version;
    logic [7:0]  frame_type;
    logic [15:0] sequence_number;
    logic [15:0] command_code;
    logic [15:0] request_status;
    logic [15:0] payload_length;
  } result_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfpd_parser.sv =====
module cfpd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        mark_first_i,
  input  logic [7:0]        mark_second_i,
  input  logic [15:0]       max_payload_i,
  output cfpd_pkg::result_t res_o
);

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] status_q, status_d;
  logic [15:0] length_q, length_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_q, crc_d;

  logic [15:0] crc_next;
  logic [15:0] pos_inc;
  logic [15:0] len_full;
  logic        do_clear;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_byte;
  logic [15:0] emit_index;

  assign crc_next = cfpd_pkg::crc16_byte(crc_q, rx_byte_i);
  assign pos_inc  = pos_q + 16'd1;
  assign len_full = {rx_byte_i, length_q[7:0]};

  // Advance the frame state by one byte
  always_comb begin
    phase_d    = phase_q;
    version_d  = version_q;
    type_d     = type_q;
    seq_d      = seq_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    length_d   = length_q;
    pos_d      = pos_q;
    crc_lo_d   = crc_lo_q;
    crc_d      = crc_q;
    do_clear   = 1'b0;
    emit       = 1'b0;
    emit_kind  = cfpd_pkg::KindPayload;
    emit_byte  = 8'h00;
    emit_index = 16'h0000;
    case (phase_q)
      cfpd_pkg::PhMark1: begin
        if (rx_byte_i == mark_first_i) phase_d = cfpd_pkg::PhMark2;
      end
      cfpd_pkg::PhMark2: begin
        if (rx_byte_i == mark_second_i) begin
          crc_d   = cfpd_pkg::CrcInit;
          pos_d   = 16'h0000;
          phase_d = cfpd_pkg::PhVer;
        end else if (rx_byte_i != mark_first_i) begin
          phase_d = cfpd_pkg::PhMark1;
        end
      end
      cfpd_pkg::PhVer: begin
        crc_d = crc_next; version_d = rx_byte_i; phase_d = cfpd_pkg::PhType;
      end
      cfpd_pkg::PhType: begin
        crc_d = crc_next; type_d = rx_byte_i; phase_d = cfpd_pkg::PhSeq0;
      end
      cfpd_pkg::PhSeq0: begin
        crc_d = crc_next; seq_d = {8'h00, rx_byte_i}; phase_d = cfpd_pkg::PhSeq1;
      end
      cfpd_pkg::PhSeq1: begin
        crc_d = crc_next; seq_d = {rx_byte_i, seq_q[7:0]}; phase_d = cfpd_pkg::PhCmd0;
      end
      cfpd_pkg::PhCmd0: begin
        crc_d = crc_next; cmd_d = {8'h00, rx_byte_i}; phase_d = cfpd_pkg::PhCmd1;
      end
      cfpd_pkg::PhCmd1: begin
        crc_d = crc_next; cmd_d = {rx_byte_i, cmd_q[7:0]}; phase_d = cfpd_pkg::PhSt0;
      end
      cfpd_pkg::PhSt0: begin
        crc_d = crc_next; status_d = {8'h00, rx_byte_i}; phase_d = cfpd_pkg::PhSt1;
      end
      cfpd_pkg::PhSt1: begin
        crc_d = crc_next; status_d = {rx_byte_i, status_q[7:0]};
        phase_d = cfpd_pkg::PhLen0;
      end
      cfpd_pkg::PhLen0: begin
        crc_d = crc_next; length_d = {8'h00, rx_byte_i}; phase_d = cfpd_pkg::PhLen1;
      end
      cfpd_pkg::PhLen1: begin
        crc_d    = crc_next;
        length_d = len_full;
        // Drop frames whose length exceeds the limit
        if (len_full > max_payload_i) do_clear = 1'b1;
        else if (len_full == 16'h0000) phase_d = cfpd_pkg::PhCrc0;
        else phase_d = cfpd_pkg::PhData;
      end
      cfpd_pkg::PhData: begin
        crc_d      = crc_next;
        pos_d      = pos_inc;
        if (pos_inc >= length_q) phase_d = cfpd_pkg::PhCrc0;
        emit       = 1'b1;
        emit_kind  = cfpd_pkg::KindPayload;
        emit_byte  = rx_byte_i;
        emit_index = pos_q;
      end
      cfpd_pkg::PhCrc0: begin
        crc_lo_d = rx_byte_i;
        phase_d  = cfpd_pkg::PhCrc1;
      end
      cfpd_pkg::PhCrc1: begin
        emit      = 1'b1;
        emit_kind = ({rx_byte_i, crc_lo_q} == crc_q) ? cfpd_pkg::KindCrcGood
                                                     : cfpd_pkg::KindCrcBad;
        do_clear  = 1'b1;
      end
      default: do_clear = 1'b1;
    endcase
    if (do_clear) begin
      phase_d   = cfpd_pkg::PhMark1;
      version_d = 8'h00;
      type_d    = 8'h00;
      seq_d     = 16'h0000;
      cmd_d     = 16'h0000;
      status_d  = 16'h0000;
      length_d  = 16'h0000;
      pos_d     = 16'h0000;
      crc_lo_d  = 8'h00;
      crc_d     = cfpd_pkg::CrcInit;
    end
  end

  // Result carries the header as held before any clear
  always_comb begin
    res_o.valid           = step_i & emit;
    res_o.kind            = emit_kind;
    res_o.payload_byte    = emit_byte;
    res_o.payload_index   = emit_index;
    res_o.frame_version   = version_q;
    res_o.frame_type      = type_q;
    res_o.sequence_number = seq_q;
    res_o.command_code    = cmd_q;
    res_o.request_status  = status_q;
    res_o.payload_length  = length_q;
  end

  // Hold the frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfpd_pkg::PhMark1;
      version_q <= 8'h00;
      type_q   <= 8'h00;
      seq_q    <= 16'h0000;
      cmd_q    <= 16'h0000;
      status_q <= 16'h0000;
      length_q <= 16'h0000;
      pos_q    <= 16'h0000;
      crc_lo_q <= 8'h00;
      crc_q    <= cfpd_pkg::CrcInit;
    end else if (step_i) begin
      phase_q  <= phase_d;
      version_q <= version_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
      length_q <= length_d;
      pos_q    <= pos_d;
      crc_lo_q <= crc_lo_d;
      crc_q    <= crc_d;
    end
  end

endmodule

// ===== hdl/crc_framed_packet_deframer.sv =====
// Channel | Direction | Signals
// rx      | in        | rx_valid_i, rx_ready_o, rx_byte_i
// out     | out       | out_valid_o, out_ready_i, kind_o, payload_*_o, header fields
// cfg     | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while the out channel is not stalled: a byte is held in
// the input register, then the parser step (byte-wide CRC update plus phase logic) loads
// the result register.
// Reset returns the phase, header hold registers, CRC and the mark/limit registers
// to their defaults.
// A stalled out beat still lets one more byte into the input register; after that
// rx_ready_o drops until the result is taken. Config writes are always ready.
module crc_framed_packet_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   payload_byte_o,
  output logic [15:0]                  payload_index_o,
  output logic [7:0]                   frame_version_o,
  output logic [7:0]                   frame_type_o,
  output logic [15:0]                  sequence_number_o,
  output logic [15:0]                  command_code_o,
  output logic [15:0]                  request_status_o,
  output logic [15:0]                  payload_length_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfpd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);

  logic [7:0]        mark_first_q;
  logic [7:0]        mark_second_q;
  logic [15:0]       max_payload_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              consume;
  cfpd_pkg::result_t res;
  cfpd_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_first_q  <= cfpd_pkg::MarkFirstRst;
      mark_second_q <= cfpd_pkg::MarkSecondRst;
      max_payload_q <= cfpd_pkg::MaxPayloadRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cfpd_pkg::CfgMarkFirst:  mark_first_q  <= cfg_data_i[7:0];
        cfpd_pkg::CfgMarkSecond: mark_second_q <= cfg_data_i[7:0];
        cfpd_pkg::CfgMaxPayload: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Step the parser when the result slot is free or draining
  assign consume    = in_valid_q & (~out_valid_q | out_ready_i);
  assign rx_ready_o = ~in_valid_q | consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) in_byte_q <= rx_byte_i;
  end

  cfpd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (consume),
    .rx_byte_i     (in_byte_q),
    .mark_first_i  (mark_first_q),
    .mark_second_i (mark_second_q),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  // Result register
  always_comb begin
    if (res.valid) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) out_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign payload_byte_o    = out_q.payload_byte;
  assign payload_index_o   = out_q.payload_index;
  assign frame_version_o   = out_q.frame_version;
  assign frame_type_o      = out_q.frame_type;
  assign sequence_number_o = out_q.sequence_number;
  assign command_code_o    = out_q.command_code;
  assign request_status_o  = out_q.request_status;
  assign payload_length_o  = out_q.payload_length;

  // A parser result never lands on a waiting, untaken beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending beat");

  // A held byte that is not stepped stays in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !consume) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input byte lost");

  // Frame-end beats carry zero payload byte and index
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != cfpd_pkg::KindPayload) |->
      (payload_byte_o == 8'h00 && payload_index_o == 16'h0000))
    else $error("frame-end beat with payload data");

  // Payload index stays inside the declared length
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == cfpd_pkg::KindPayload) |-> (payload_index_o < payload_length_o))
    else $error("payload index beyond length");

endmodule
